FILE: rtl/qrs_pkg.sv
// Package for the quadratic root solver: widths, stage records and codes.
// Used by quadratic_root_solver_top; depends on nothing.
`timescale 1ns / 1ps
package qrs_pkg;
	localparam int DW    = 32;
	localparam int FB    = 16;
	localparam int PW    = 2 * DW;
	localparam int DISCW = 2 * DW + 2;
	localparam int SW    = DISCW / 2;
	localparam int RW    = SW + 3;
	localparam int NMW   = DW + 2;
	localparam int NW    = NMW + FB;
	localparam int DIVW  = DW + 1;

	typedef enum logic [1:0] {
		DISC_NEG  = 2'd0,
		DISC_ZERO = 2'd1,
		DISC_POS  = 2'd2
	} disc_cls_t;

	typedef struct packed {
		logic            a_zero;
		logic            a_neg;
		logic [DW-1:0]   a_mag;
		logic            b_neg;
		logic [DW-1:0]   b_mag;
		disc_cls_t       cls;
	} side_t;

	typedef struct packed {
		logic [DISCW-1:0] dsh;
		logic [RW-1:0]    rem;
		logic [SW-1:0]    root;
	} sqrt_t;

	typedef struct packed {
		logic [NW-1:0]   nsh;
		logic [DIVW-1:0] rem;
		logic [NW-1:0]   q;
		logic            neg;
	} div_t;
endpackage

FILE: rtl/quadratic_root_solver_top.sv
// Pipelined real roots of a*x^2 + b*x + c in signed Q16.16.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
// channel | valid      | stall      | payload
// coef    | coef_valid | coef_stall | coef_a, coef_b, coef_c
// root    | root_valid | root_stall | root_count, root_plus, root_minus, overflow, invalid_lead
// One item per cycle while the root channel is not stalled; one square root bit
// per stage, one quotient bit per divider stage.
// Reset clears all valid bits; payload registers are not reset.
// A stall on the root channel while root_valid is set freezes the whole pipeline and stalls coef.
module quadratic_root_solver_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         coef_valid,
	output logic                         coef_stall,
	input  logic signed [qrs_pkg::DW-1:0] coef_a,
	input  logic signed [qrs_pkg::DW-1:0] coef_b,
	input  logic signed [qrs_pkg::DW-1:0] coef_c,
	output logic                         root_valid,
	input  logic                         root_stall,
	output logic [1:0]                   root_count,
	output logic signed [qrs_pkg::DW-1:0] root_plus,
	output logic signed [qrs_pkg::DW-1:0] root_minus,
	output logic                         overflow,
	output logic                         invalid_lead
);
	import qrs_pkg::*;

	logic en;
	assign en = !(root_valid && root_stall);
	assign coef_stall = !en;

	// stage 1: split signs and magnitudes
	logic          v_s1;
	side_t         sd_s1;
	logic          c_neg_s1;
	logic [DW-1:0] c_mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= coef_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.a_neg  <= coef_a[DW-1];
			sd_s1.a_mag  <= coef_a[DW-1] ? DW'(-coef_a) : DW'(coef_a);
			sd_s1.a_zero <= coef_a == '0;
			sd_s1.b_neg  <= coef_b[DW-1];
			sd_s1.b_mag  <= coef_b[DW-1] ? DW'(-coef_b) : DW'(coef_b);
			sd_s1.cls    <= DISC_NEG;
			c_neg_s1     <= coef_c[DW-1];
			c_mag_s1     <= coef_c[DW-1] ? DW'(-coef_c) : DW'(coef_c);
		end
	end

	// stage 2: products
	logic          v_s2;
	side_t         sd_s2;
	logic          c_neg_s2;
	logic [PW-1:0] bsq_s2, ac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2    <= sd_s1;
			c_neg_s2 <= c_neg_s1;
			bsq_s2   <= sd_s1.b_mag * sd_s1.b_mag;
			ac_s2    <= sd_s1.a_mag * c_mag_s1;
		end
	end

	// stage 3: discriminant and its class
	logic             v_s3;
	side_t            sd_s3;
	logic [DISCW-1:0] disc_s3;
	logic [DISCW-1:0] bsq_x, ac4_x, sum_x, dif_x;
	disc_cls_t        cls_x;
	logic [DISCW-1:0] disc_x;
	side_t            sd_x;

	always_comb begin
		bsq_x = DISCW'(bsq_s2);
		ac4_x = {ac_s2, 2'b00};
		sum_x = bsq_x + ac4_x;
		dif_x = bsq_x - ac4_x;
		if (sd_s2.a_neg != c_neg_s2) begin
			disc_x = sum_x;
			cls_x  = (sum_x == '0) ? DISC_ZERO : DISC_POS;
		end else if (bsq_x < ac4_x) begin
			disc_x = '0;
			cls_x  = DISC_NEG;
		end else begin
			disc_x = dif_x;
			cls_x  = (dif_x == '0) ? DISC_ZERO : DISC_POS;
		end
		sd_x     = sd_s2;
		sd_x.cls = cls_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3   <= sd_x;
			disc_s3 <= disc_x;
		end
	end

	// square root, one result bit per stage
	logic  sq_v_s [0:SW];
	side_t sq_sd_s [0:SW];
	sqrt_t sq_s [0:SW];

	always_comb begin
		sq_v_s[0]  = v_s3;
		sq_sd_s[0] = sd_s3;
		sq_s[0]    = '{dsh: disc_s3, rem: '0, root: '0};
	end

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		logic [RW-1:0] r2, trial;
		sqrt_t         nx;
		always_comb begin
			r2    = {sq_s[i].rem[RW-3:0], sq_s[i].dsh[DISCW-1 -: 2]};
			trial = RW'({sq_s[i].root, 2'b01});
			nx.dsh = {sq_s[i].dsh[DISCW-3:0], 2'b00};
			if (r2 >= trial) begin
				nx.rem  = r2 - trial;
				nx.root = {sq_s[i].root[SW-2:0], 1'b1};
			end else begin
				nx.rem  = r2;
				nx.root = {sq_s[i].root[SW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[i+1] <= 1'b0;
			else if (en) sq_v_s[i+1] <= sq_v_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_sd_s[i+1] <= sq_sd_s[i];
				sq_s[i+1]    <= nx;
			end
		end
	end

	// numerators -b + s and -b - s
	logic signed [NMW:0] negb_x, nump_x, numm_x, s_x;
	always_comb begin
		s_x    = (NMW+1)'(sq_s[SW].root);
		negb_x = sq_sd_s[SW].b_neg ? (NMW+1)'(sq_sd_s[SW].b_mag)
		                           : -(NMW+1)'(sq_sd_s[SW].b_mag);
		nump_x = negb_x + s_x;
		numm_x = negb_x - s_x;
	end

	logic  dv_s [0:NW];
	side_t dsd_s [0:NW];
	div_t  dp_s [0:NW];
	div_t  dm_s [0:NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else if (en) dv_s[0] <= sq_v_s[SW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsd_s[0]    <= sq_sd_s[SW];
			dp_s[0].nsh <= {(nump_x[NMW] ? NMW'(-nump_x) : NMW'(nump_x)), FB'(0)};
			dp_s[0].neg <= nump_x[NMW] ^ sq_sd_s[SW].a_neg;
			dp_s[0].rem <= '0;
			dp_s[0].q   <= '0;
			dm_s[0].nsh <= {(numm_x[NMW] ? NMW'(-numm_x) : NMW'(numm_x)), FB'(0)};
			dm_s[0].neg <= numm_x[NMW] ^ sq_sd_s[SW].a_neg;
			dm_s[0].rem <= '0;
			dm_s[0].q   <= '0;
		end
	end

	// two restoring dividers by 2a, one quotient bit per stage
	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [DIVW:0] dd, rp, rm;
		div_t          np, nm;
		always_comb begin
			dd = {1'b0, dsd_s[i].a_mag, 1'b0};
			rp = {dp_s[i].rem, dp_s[i].nsh[NW-1]};
			rm = {dm_s[i].rem, dm_s[i].nsh[NW-1]};
			np.nsh = {dp_s[i].nsh[NW-2:0], 1'b0};
			np.neg = dp_s[i].neg;
			nm.nsh = {dm_s[i].nsh[NW-2:0], 1'b0};
			nm.neg = dm_s[i].neg;
			if (rp >= dd) begin
				np.rem = DIVW'(rp - dd);
				np.q   = {dp_s[i].q[NW-2:0], 1'b1};
			end else begin
				np.rem = DIVW'(rp);
				np.q   = {dp_s[i].q[NW-2:0], 1'b0};
			end
			if (rm >= dd) begin
				nm.rem = DIVW'(rm - dd);
				nm.q   = {dm_s[i].q[NW-2:0], 1'b1};
			end else begin
				nm.rem = DIVW'(rm);
				nm.q   = {dm_s[i].q[NW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[i+1] <= 1'b0;
			else if (en) dv_s[i+1] <= dv_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dsd_s[i+1] <= dsd_s[i];
				dp_s[i+1]  <= np;
				dm_s[i+1]  <= nm;
			end
		end
	end

	// saturate, sign and select by root count
	logic [NW-1:0] limp_x, limm_x;
	logic          ovp_x, ovm_x;
	logic [DW-1:0] qp_x, qm_x, rpv_x, rmv_x;
	logic [1:0]    cnt_x;
	logic [DW-1:0] op_x, om_x;
	logic          of_x;

	always_comb begin
		limp_x = NW'({1'b0, {(DW-1){1'b1}}}) + NW'(dp_s[NW].neg);
		limm_x = NW'({1'b0, {(DW-1){1'b1}}}) + NW'(dm_s[NW].neg);
		ovp_x  = dp_s[NW].q > limp_x;
		ovm_x  = dm_s[NW].q > limm_x;
		qp_x   = ovp_x ? DW'(limp_x) : DW'(dp_s[NW].q);
		qm_x   = ovm_x ? DW'(limm_x) : DW'(dm_s[NW].q);
		rpv_x  = dp_s[NW].neg ? -qp_x : qp_x;
		rmv_x  = dm_s[NW].neg ? -qm_x : qm_x;
		cnt_x  = 2'd0;
		op_x   = '0;
		om_x   = '0;
		of_x   = 1'b0;
		if (!dsd_s[NW].a_zero) begin
			case (dsd_s[NW].cls)
				DISC_ZERO: begin
					cnt_x = 2'd1;
					op_x  = rpv_x;
					of_x  = ovp_x;
				end
				DISC_POS: begin
					cnt_x = 2'd2;
					op_x  = rpv_x;
					om_x  = rmv_x;
					of_x  = ovp_x | ovm_x;
				end
				default: begin
					cnt_x = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_valid <= 1'b0;
		else if (en) root_valid <= dv_s[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_count   <= cnt_x;
			root_plus    <= op_x;
			root_minus   <= om_x;
			overflow     <= of_x;
			invalid_lead <= dsd_s[NW].a_zero;
		end
	end

`ifndef ASSERT_OFF
	a_lead_no_roots: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && invalid_lead |-> root_count == 2'd0 && !overflow)
		else $error("invalid lead with roots");
	a_zero_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_count == 2'd0 |-> root_plus == '0 && root_minus == '0)
		else $error("roots present with zero count");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid |-> root_count != 2'd3)
		else $error("root count out of range");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		coef_stall |=> $stable(dv_s[0]))
		else $error("pipeline moved under stall");
`endif
endmodule
